[rtl/linear_interpolation_resampler_assert.svh]
// assertion macros used by the resampler back end
`ifndef LINEAR_INTERPOLATION_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERPOLATION_RESAMPLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LIR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lir assertion failed");

// next-cycle implication
`define LIR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lir assertion failed");

`endif

[rtl/lir_pkg.sv]
// types and constants of the linear interpolation resampler
package lir_pkg;

    localparam int WL_W  = 16;
    localparam int VAL_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int CFG_INDEX_W = 8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REGION_INTERP = 2'd0;
    localparam logic [1:0] REGION_EXACT  = 2'd1;
    localparam logic [1:0] REGION_BELOW  = 2'd2;
    localparam logic [1:0] REGION_ABOVE  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_BEYOND  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_COUNT = 8'd1;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        entry_index;
        logic [WL_W-1:0]         wavelength;
        logic signed [VAL_W-1:0] sample_value;
    } item_t;

endpackage

[rtl/linear_interpolation_resampler.sv]
// linear_interpolation_resampler: piecewise-linear lookup over a loaded point table
// Load requests (tuser 0) write a point into the table; query requests (tuser 1)
// give one result each, by a binary search over the single read port of the
// table and, for points between two entries, the bit-serial fraction divider.
// Out-of-range queries skip the search and the divider. A two-deep request queue
// lets new requests be taken while the back end works, and a result register
// holds the answer until the sink takes it. Table entries never written read
// back as garbage; there is no clearing pass after reset.
module linear_interpolation_resampler
    import lir_pkg::*;
#(
    parameter int MAX_POINTS    = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [55:0]            s_axis_tdata,  // entry_index, wavelength, sample_value
    input  logic                   s_axis_tuser,  // cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,  // result_value
    output logic [1:0]             m_axis_tuser,  // region
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]       cfg_data
);

    logic             zero_beyond_reg;
    logic [CNT_W-1:0] source_count_reg;
    logic             q_valid, q_pop;
    item_t            q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_beyond_reg  <= 1'b0;
            source_count_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ZERO_BEYOND)
            begin
                zero_beyond_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_SOURCE_COUNT)
            begin
                source_count_reg <= cfg_data;
            end
        end
    end

    lir_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    lir_back #(
        .MAX_POINTS    (MAX_POINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .zero_beyond  (zero_beyond_reg),
        .source_count (source_count_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_value    (m_axis_tdata),
        .out_region   (m_axis_tuser)
    );

endmodule

[rtl/lir_ram.sv]
// generic simple dual-port ram with registered read
module lir_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lir_front.sv]
// front end: takes requests, unpacks them and queues them for the back end
module lir_front
    import lir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [55:0] s_data,
    input  logic        s_user,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    item_t      incoming;

    assign incoming.cmd          = s_user;
    assign incoming.entry_index  = s_data[5:0];
    assign incoming.wavelength   = s_data[21:6];
    assign incoming.sample_value = s_data[53:22];

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

[rtl/lir_div.sv]
// restoring divider for the interpolation fraction, one quotient bit per cycle
module lir_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [15:0]              num,
    input  logic [15:0]              den,
    output logic                     done,
    output logic [FRACTION_BITS-1:0] quot
);

    localparam int STEP_W = $clog2(FRACTION_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [15:0]              rem_reg;
    logic [15:0]              den_reg;
    logic [FRACTION_BITS-1:0] quot_reg;
    logic [16:0]              shifted;
    logic                     fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(FRACTION_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator is below the divisor, so the remainder stays 16 bits wide
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? 16'(shifted - {1'b0, den_reg}) : shifted[15:0];
            quot_reg <= {quot_reg[FRACTION_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/lir_back.sv]
// back end: table writes, binary search, fraction and interpolation
module lir_back
    import lir_pkg::*;
#(
    parameter int MAX_POINTS    = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    input  logic               zero_beyond,
    input  logic [CNT_W-1:0]   source_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VAL_W-1:0]   out_value,
    output logic [1:0]         out_region
);

`include "linear_interpolation_resampler_assert.svh"

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int PW = VAL_W + FRACTION_BITS + 2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIRST = 10'b0000000010,
        S_LAST  = 10'b0000000100,
        S_PROBE = 10'b0000001000,
        S_CMP   = 10'b0000010000,
        S_HI    = 10'b0000100000,
        S_LO    = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_ADD   = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [WL_W-1:0]         w_reg;
    logic [NW-1:0]           first_reg, cnt_reg, step_reg;
    logic [AW-1:0]           hi_reg;
    logic [WL_W-1:0]         wlh_reg;
    logic signed [VAL_W-1:0] vh_reg, vl_reg;
    logic signed [VAL_W:0]   diff_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [VAL_W-1:0] res_reg;
    logic [1:0]              region_reg;
    logic                    out_valid_reg;
    logic [VAL_W-1:0]        out_value_reg;
    logic [1:0]              out_region_reg;

    logic [NW-1:0]           n_active;
    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [WL_W+VAL_W-1:0]   ram_rdata;
    logic [WL_W-1:0]         rd_wl;
    logic signed [VAL_W-1:0] rd_val;
    logic                    div_start, div_done;
    logic [FRACTION_BITS-1:0] div_quot;
    logic [NW-1:0]           half;
    logic                    out_free;
    logic signed [PW-1:0]    prod_shift;

    // zero acts as one, anything past the table depth as the depth
    always_comb
    begin
        priority if (source_count == '0)
            n_active = NW'(1);
        else if ({25'd0, source_count} > 32'(MAX_POINTS))
            n_active = NW'(MAX_POINTS);
        else
            n_active = NW'(source_count);
    end

    assign rd_wl    = ram_rdata[WL_W-1:0];
    assign rd_val   = ram_rdata[WL_W+VAL_W-1:WL_W];
    assign half     = cnt_reg >> 1;
    assign out_free = !out_valid_reg || out_ready;
    assign prod_shift = prod_reg >>> FRACTION_BITS;

    assign ram_we = (state_reg == S_IDLE) && q_valid && (q_item.cmd == CMD_LOAD)
                    && ({26'd0, q_item.entry_index} < 32'(MAX_POINTS));
    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign div_start = (state_reg == S_LO);

    always_comb
    begin
        state_next = state_reg;
        ram_raddr  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_item.cmd == CMD_QUERY)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                ram_raddr  = AW'(n_active - 1'b1);
                state_next = (w_reg < rd_wl) ? S_EMIT : S_LAST;
            end
            S_LAST:
            begin
                state_next = (w_reg > rd_wl) ? S_EMIT : S_PROBE;
            end
            S_PROBE:
            begin
                if (cnt_reg == '0)
                begin
                    ram_raddr  = AW'(first_reg);
                    state_next = S_HI;
                end
                else
                begin
                    ram_raddr  = AW'(first_reg + half);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_PROBE;
            end
            S_HI:
            begin
                ram_raddr = hi_reg - 1'b1;
                state_next = (hi_reg == '0 || rd_wl == w_reg) ? S_EMIT : S_LO;
            end
            S_LO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                w_reg <= q_item.wavelength;
            end
            S_FIRST:
            begin
                region_reg <= REGION_BELOW;
                res_reg    <= zero_beyond ? '0 : rd_val;
            end
            S_LAST:
            begin
                region_reg <= REGION_ABOVE;
                res_reg    <= zero_beyond ? '0 : rd_val;
                first_reg  <= '0;
                cnt_reg    <= n_active;
            end
            S_PROBE:
            begin
                step_reg <= half;
                hi_reg   <= AW'(first_reg);
            end
            S_CMP:
            begin
                if (rd_wl < w_reg)
                begin
                    first_reg <= first_reg + step_reg + 1'b1;
                    cnt_reg   <= cnt_reg - step_reg - 1'b1;
                end
                else
                begin
                    cnt_reg <= step_reg;
                end
            end
            S_HI:
            begin
                wlh_reg    <= rd_wl;
                vh_reg     <= rd_val;
                region_reg <= REGION_EXACT;
                res_reg    <= rd_val;
            end
            S_LO:
            begin
                vl_reg   <= rd_val;
                diff_reg <= (VAL_W+1)'(vh_reg) - (VAL_W+1)'(rd_val);
            end
            S_DIV:
            begin
                prod_reg <= PW'(diff_reg * $signed({1'b0, div_quot}));
            end
            S_ADD:
            begin
                region_reg <= REGION_INTERP;
                res_reg    <= vl_reg + prod_shift[VAL_W-1:0];
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_value_reg  <= res_reg;
                    out_region_reg <= region_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    lir_ram #(
        .WIDTH (WL_W + VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(q_item.entry_index)),
        .wdata ({q_item.sample_value, q_item.wavelength}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lir_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (w_reg - rd_wl),
        .den   (wlh_reg - rd_wl),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_region = out_region_reg;

    `LIR_ASSERT_IMP(a_write_only_idle, ram_we, state_reg == S_IDLE)
    `LIR_ASSERT_NXT(a_zero_beyond, state_reg == S_EMIT && out_free && zero_beyond
        && (region_reg == REGION_BELOW || region_reg == REGION_ABOVE), out_value_reg == '0)
    `LIR_ASSERT_IMP(a_done_in_div, div_done, state_reg == S_DIV)

endmodule

[bench/tb_linear_interpolation_resampler.sv]
// self-checking testbench for the linear interpolation resampler
`timescale 1ns / 100ps

module tb_linear_interpolation_resampler;
    import lir_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         region;
    } answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [55:0]            s_axis_tdata = '0;   // entry_index, wavelength, sample_value
    logic                   s_axis_tuser = 1'b0; // cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;        // result_value
    logic [1:0]             m_axis_tuser;        // region
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]       cfg_data = '0;

    linear_interpolation_resampler uut (.*);

    always #5 clk = ~clk;

    // shadow state of the table and registers
    logic [15:0]        shadow_wl [TABLE_DEPTH];
    logic signed [31:0] shadow_val [TABLE_DEPTH];
    logic               zero_out = 1'b0;
    int                 count_reg = 1;

    answer_t pending_answers[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_off = 1'b0;
    int      hold_cycles = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic int active_points();
        int n;
        n = count_reg;
        if (n < 1) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n;
    endfunction

    function automatic answer_t interpolate(input logic [15:0] w);
        answer_t a;
        int n, first, cnt, step, hi, lo;
        longint num, den, frac, diff, prod;
        n = active_points();
        if (w < shadow_wl[0]) begin
            a.region = REGION_BELOW;
            a.value = zero_out ? 32'sd0 : shadow_val[0];
        end else if (w > shadow_wl[n-1]) begin
            a.region = REGION_ABOVE;
            a.value = zero_out ? 32'sd0 : shadow_val[n-1];
        end else begin
            first = 0;
            cnt = n;
            while (cnt > 0) begin
                step = cnt / 2;
                if (shadow_wl[first+step] < w) begin
                    first += step + 1;
                    cnt -= step + 1;
                end else cnt = step;
            end
            hi = (first >= n) ? n - 1 : first;
            if (hi == 0 || shadow_wl[hi] == w) begin
                a.region = REGION_EXACT;
                a.value = shadow_val[hi];
            end else begin
                lo = hi - 1;
                den = longint'(shadow_wl[hi]) - longint'(shadow_wl[lo]);
                num = longint'(w) - longint'(shadow_wl[lo]);
                frac = (den != 0) ? (num << FRAC) / den : 0;
                diff = longint'(shadow_val[hi]) - longint'(shadow_val[lo]);
                prod = diff * frac;
                a.region = REGION_INTERP;
                a.value = 32'(longint'(shadow_val[lo]) + (prod >>> FRAC));
            end
        end
        return a;
    endfunction

    // valid stays up after an accepted request until the sender idles or drains
    task automatic send_request(input logic cmd, input logic [5:0] idx,
                                input logic [15:0] w, input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {2'b00, v, w, idx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (cmd == CMD_LOAD) begin
            shadow_wl[idx] = w;
            shadow_val[idx] = v;
        end else pending_answers.insert(pending_answers.size(), interpolate(w));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input int val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CNT_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ZERO_BEYOND) zero_out = val[0];
        else if (idx == CFG_SOURCE_COUNT) count_reg = val;
    endtask

    // random table of n points, ascending when sorted is set, wavelengths spread over the full range
    task automatic load_table(input int n, input bit sorted);
        int w;
        w = $urandom_range(200);
        for (int i = 0; i < n; i++) begin
            send_request(CMD_LOAD, 6'(i), sorted ? 16'(w) : 16'($urandom),
                         ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 22)) - 32'sd2097152);
            w += 1 + $urandom_range(65535 / n);
            if (w > 65535) w = 65535;
        end
    endtask

    // queries reach only slots below count, which are all written first
    task automatic random_query();
        int n, k;
        logic [15:0] w;
        n = active_points();
        k = $urandom_range(n - 1);
        case ($urandom_range(4))
            0: w = shadow_wl[k];
            1: w = shadow_wl[k] + 16'($urandom_range(3));
            default: w = 16'($urandom);
        endcase
        send_request(CMD_QUERY, 6'($urandom), w, $urandom);
    endtask

    task automatic test_directed();
        write_register(CFG_SOURCE_COUNT, 4);
        write_register(CFG_ZERO_BEYOND, 0);
        send_request(CMD_LOAD, 6'd0, 16'd100, 32'h7fff_ffff);
        send_request(CMD_LOAD, 6'd1, 16'd200, 32'h8000_0000);
        send_request(CMD_LOAD, 6'd2, 16'd300, 32'h0001_0000);
        send_request(CMD_LOAD, 6'd3, 16'hffff, 32'hffff_0000);
        send_request(CMD_LOAD, 6'd63, 16'hffff, 32'h1234_5678);
        send_request(CMD_QUERY, 6'd0, 16'd0, 32'h0);
        send_request(CMD_QUERY, 6'd63, 16'd100, 32'hffff_ffff);
        send_request(CMD_QUERY, 6'd0, 16'd150, 32'h0);
        send_request(CMD_QUERY, 6'd0, 16'd199, 32'h0);
        send_request(CMD_QUERY, 6'd0, 16'd200, 32'h0);
        send_request(CMD_QUERY, 6'd0, 16'd301, 32'h0);
        send_request(CMD_QUERY, 6'd0, 16'hffff, 32'h0);
        write_register(CFG_ZERO_BEYOND, 1);
        send_request(CMD_QUERY, 6'd0, 16'd5, 32'h0);
        send_request(CMD_QUERY, 6'd0, 16'd250, 32'h0);
        write_register(CFG_SOURCE_COUNT, 2);
        send_request(CMD_QUERY, 6'd0, 16'd250, 32'h0);
        // unsorted table still runs the same search
        send_request(CMD_LOAD, 6'd0, 16'd500, 32'h0002_0000);
        send_request(CMD_LOAD, 6'd1, 16'd50, 32'h0003_0000);
        write_register(CFG_SOURCE_COUNT, 0);
        send_request(CMD_QUERY, 6'd0, 16'd500, 32'h0);
        send_request(CMD_QUERY, 6'd0, 16'd600, 32'h0);
        write_register(CFG_SOURCE_COUNT, 127);
        load_table(64, 1'b1);
        send_request(CMD_QUERY, 6'd0, 16'h8000, 32'h0);
        send_request(CMD_QUERY, 6'd0, 16'hfffe, 32'h0);
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int items);
        int n;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        n = ($urandom_range(5) == 0) ? 64 : 2 + $urandom_range(10);
        write_register(CFG_ZERO_BEYOND, $urandom_range(1));
        write_register(CFG_SOURCE_COUNT, n);
        load_table(n, $urandom_range(9) != 0);
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(19) == 0)
                send_request(CMD_LOAD, 6'($urandom_range(n - 1)), 16'($urandom), $urandom);
            else random_query();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 600;
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++) random_query();
        drain();
        for (int i = 0; i < 10; i++) random_query();
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
            else hold_off <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata, 0);
            else
            begin
                want = pending_answers.pop_front();
                if ($signed(m_axis_tdata) !== want.value)
                    report_mismatch("result_value", $signed(m_axis_tdata), want.value);
                if (m_axis_tuser !== want.region)
                    report_mismatch("region", m_axis_tuser, want.region);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 0, 350);
        test_random_phase(78, 0, 300);
        test_random_phase(0, 78, 300);
        test_random_phase(7, 7, 350);
        test_backpressure();
        drain();
        if (error_count == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
